/* sv/kmhc_pkg.sv */
`timescale 1ns / 1ps
package kmhc_pkg;

  localparam int MAX_K_DEF         = 8;
  localparam int COUNT_WIDTH_DEF   = 16;
  localparam int MODE_W            = 2;
  localparam int SYMBOL_W          = 8;
  localparam int INDEX_W           = 16;
  localparam int COUNT_OUT_W       = 16;
  localparam int STATUS_W          = 2;
  localparam int KLEN_W            = 4;
  localparam int QUEUE_DEPTH       = 2;
  localparam int APB_ADDR_W        = 3;
  localparam int APB_DATA_W        = 32;
  localparam int KMER_LENGTH_RESET = 4;
  localparam int UNKNOWN_RESET     = 78;

  localparam logic [SYMBOL_W-1:0] CHAR_C = 8'h43;
  localparam logic [SYMBOL_W-1:0] CHAR_T = 8'h54;
  localparam logic [SYMBOL_W-1:0] CHAR_A = 8'h41;
  localparam logic [SYMBOL_W-1:0] CHAR_G = 8'h47;

  typedef enum logic [1:0] {
    MODE_SYMBOL = 2'd0,
    MODE_READ   = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_INCR  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_STAT  = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic     stat;
    logic     seen;
  } op_ctl_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_SEGMENT = 2'd1,
    ST_OVERFLOW   = 2'd2
  } status_t;

  typedef enum logic {
    RK_READ   = 1'b0,
    RK_STATUS = 1'b1
  } result_kind_t;

  typedef enum logic {
    REG_KMER_LENGTH    = 1'b0,
    REG_UNKNOWN_SYMBOL = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    B_CLEAR = 2'd0,
    B_IDLE  = 2'd1,
    B_DATA  = 2'd2
  } back_state_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] digit;
  } digit_t;

  function automatic digit_t base_digit(input logic [SYMBOL_W-1:0] c);
    digit_t d;
    d.ok    = 1'b1;
    d.digit = 2'd0;
    if (c == CHAR_C) begin
      d.digit = 2'd0;
    end else if (c == CHAR_T) begin
      d.digit = 2'd1;
    end else if (c == CHAR_A) begin
      d.digit = 2'd2;
    end else if (c == CHAR_G) begin
      d.digit = 2'd3;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

  function automatic logic [STATUS_W-1:0] status_code(input logic ovf, input logic seen);
    logic [STATUS_W-1:0] s;
    if (ovf) begin
      s = ST_OVERFLOW;
    end else if (seen) begin
      s = ST_OK;
    end else begin
      s = ST_NO_SEGMENT;
    end
    return s;
  endfunction

endpackage

/* sv/kmer_histogram_counter.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  mode, symbol, last_symbol, read_index
// out      output     out_valid / out_stall result_kind, count_value, status
// cfg      input      APB psel / penable   paddr, pwdata, prdata (kmer_length, unknown_symbol)
//
// The front takes one item per cycle while its two-entry queue has room.
// The back retires one counter update or read per cycle while such ops follow each other
// and no stalled output holds it up, forwarding the updated count when the same counter is
// hit twice in a row; a status-only op or a clear is handled on its own in the idle state
// of the back, and the counter op after it starts its memory read from that idle state.
// After reset and after every clear item the back sweeps all 4**MAX_K counter entries
// (65536 by default), one entry a cycle; no item is accepted during the reset sweep.
// A stalled output holds its result; in_stall is raised by a full queue or the reset sweep.
module kmer_histogram_counter import kmhc_pkg::*; #(
  parameter int MAX_K       = MAX_K_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [MODE_W-1:0]      mode,
  input  logic [SYMBOL_W-1:0]    symbol,
  input  logic                   last_symbol,
  input  logic [INDEX_W-1:0]     read_index,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   result_kind,
  output logic [COUNT_OUT_W-1:0] count_value,
  output logic [STATUS_W-1:0]    status,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int ADDR_W = 2 * MAX_K;
  localparam int CTL_W  = $bits(op_ctl_t);
  localparam int QW     = CTL_W + ADDR_W;

  logic [KLEN_W-1:0]   kmer_length;
  logic [SYMBOL_W-1:0] unknown_symbol;
  reg_index_t          reg_sel;
  logic                cfg_write;

  logic              push;
  op_ctl_t           push_ctl;
  logic [ADDR_W-1:0] push_addr;
  logic              q_full;
  logic              pop;
  logic              head_valid;
  logic [QW-1:0]     head_data;
  op_ctl_t           head_ctl;
  logic [ADDR_W-1:0] head_addr;
  logic              init_busy;

  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[2]);
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    unique case (reg_sel)
      REG_KMER_LENGTH:    prdata = {{(APB_DATA_W - KLEN_W){1'b0}}, kmer_length};
      REG_UNKNOWN_SYMBOL: prdata = {{(APB_DATA_W - SYMBOL_W){1'b0}}, unknown_symbol};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length    <= KLEN_W'(KMER_LENGTH_RESET);
      unknown_symbol <= SYMBOL_W'(UNKNOWN_RESET);
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_KMER_LENGTH:    kmer_length    <= pwdata[KLEN_W-1:0];
        REG_UNKNOWN_SYMBOL: unknown_symbol <= pwdata[SYMBOL_W-1:0];
      endcase
    end
  end

  kmhc_front #(
    .MAX_K (MAX_K)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .symbol         (symbol),
    .last_symbol    (last_symbol),
    .read_index     (read_index),
    .kmer_length    (kmer_length),
    .unknown_symbol (unknown_symbol),
    .q_full         (q_full),
    .hold           (init_busy),
    .push           (push),
    .push_ctl       (push_ctl),
    .push_addr      (push_addr)
  );

  kmhc_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({push_ctl, push_addr}),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign head_ctl  = op_ctl_t'(head_data[QW-1:ADDR_W]);
  assign head_addr = head_data[ADDR_W-1:0];

  kmhc_back #(
    .MAX_K       (MAX_K),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_ctl    (head_ctl),
    .head_addr   (head_addr),
    .pop         (pop),
    .init_busy   (init_busy),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .count_value (count_value),
    .status      (status)
  );

endmodule

/* sv/kmhc_ram.sv */
`timescale 1ns / 1ps
module kmhc_ram #(
  parameter int WIDTH  = 16,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/kmhc_queue.sv */
`timescale 1ns / 1ps
module kmhc_queue import kmhc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (int'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (int'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= DEPTH)
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue pushed while full");

endmodule

/* sv/kmhc_front.sv */
`timescale 1ns / 1ps
module kmhc_front import kmhc_pkg::*; #(
  parameter int MAX_K = MAX_K_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MODE_W-1:0]     mode,
  input  logic [SYMBOL_W-1:0]   symbol,
  input  logic                  last_symbol,
  input  logic [INDEX_W-1:0]    read_index,
  input  logic [KLEN_W-1:0]     kmer_length,
  input  logic [SYMBOL_W-1:0]   unknown_symbol,
  input  logic                  q_full,
  input  logic                  hold,
  output logic                  push,
  output op_ctl_t               push_ctl,
  output logic [2*MAX_K-1:0]    push_addr
);

  localparam int ADDR_W = 2 * MAX_K;
  localparam int KW     = $clog2(MAX_K + 1);

  logic [ADDR_W-1:0] hash;
  logic [ADDR_W-1:0] hash_next;
  logic [KW-1:0]     run;
  logic [KW-1:0]     run_next;
  logic              seen;
  logic              seen_next;

  logic [KW-1:0]             k_eff;
  logic [KW-1:0]             run_inc;
  logic [ADDR_W-1:0]         mask;
  logic [ADDR_W-1:0]         shifted;
  logic [ADDR_W+INDEX_W-1:0] ridx_ext;
  digit_t                    dg;
  logic                      is_base;
  logic                      accept;

  assign in_stall = q_full | hold;
  assign accept   = in_valid & ~in_stall;
  assign dg       = base_digit(symbol);
  assign is_base  = dg.ok && (symbol != unknown_symbol);
  assign shifted  = (hash << 2) | ADDR_W'(dg.digit);
  assign run_inc  = (int'(run) < MAX_K) ? run + 1'b1 : run;
  assign ridx_ext = {{ADDR_W{1'b0}}, read_index};

  always_comb begin
    if (kmer_length == '0) begin
      k_eff = KW'(1);
    end else if (int'(kmer_length) > MAX_K) begin
      k_eff = KW'(MAX_K);
    end else begin
      k_eff = KW'(kmer_length);
    end
    for (int b = 0; b < ADDR_W; b++) begin
      mask[b] = (b >> 1) < int'(k_eff);
    end
  end

  always_comb begin
    hash_next     = hash;
    run_next      = run;
    seen_next     = seen;
    push          = 1'b0;
    push_ctl.kind = OP_STAT;
    push_ctl.stat = 1'b0;
    push_ctl.seen = seen;
    push_addr     = shifted & mask;
    if (accept) begin
      unique case (mode_t'(mode))
        MODE_SYMBOL: begin
          if (is_base) begin
            hash_next     = shifted;
            run_next      = run_inc;
            seen_next     = 1'b1;
            push_ctl.seen = 1'b1;
            if (run_inc >= k_eff) begin
              push          = 1'b1;
              push_ctl.kind = OP_INCR;
              push_ctl.stat = last_symbol;
            end else if (last_symbol) begin
              push          = 1'b1;
              push_ctl.stat = 1'b1;
            end
          end else begin
            hash_next = '0;
            run_next  = '0;
            if (last_symbol) begin
              push          = 1'b1;
              push_ctl.stat = 1'b1;
            end
          end
          if (last_symbol) begin
            hash_next = '0;
            run_next  = '0;
            seen_next = 1'b0;
          end
        end
        MODE_READ: begin
          push          = 1'b1;
          push_ctl.kind = OP_READ;
          push_addr     = ridx_ext[ADDR_W-1:0];
        end
        MODE_CLEAR: begin
          push          = 1'b1;
          push_ctl.kind = OP_CLEAR;
          hash_next     = '0;
          run_next      = '0;
          seen_next     = 1'b0;
        end
        MODE_NONE: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= '0;
      run  <= '0;
      seen <= 1'b0;
    end else begin
      hash <= hash_next;
      run  <= run_next;
      seen <= seen_next;
    end
  end

endmodule

/* sv/kmhc_back.sv */
`timescale 1ns / 1ps
module kmhc_back import kmhc_pkg::*; #(
  parameter int MAX_K       = MAX_K_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  op_ctl_t                head_ctl,
  input  logic [2*MAX_K-1:0]     head_addr,
  output logic                   pop,
  output logic                   init_busy,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   result_kind,
  output logic [COUNT_OUT_W-1:0] count_value,
  output logic [STATUS_W-1:0]    status
);

  localparam int ADDR_W = 2 * MAX_K;

  back_state_t state;
  back_state_t state_next;
  logic [ADDR_W-1:0]      ptr;
  logic [ADDR_W-1:0]      ptr_next;
  logic                   init_next;
  logic                   overflow;
  logic                   overflow_next;
  logic                   fwd_hit;
  logic                   fwd_hit_next;
  logic [COUNT_WIDTH-1:0] fwd_data;
  logic [COUNT_WIDTH-1:0] fwd_data_next;
  op_ctl_t                cur_ctl;
  op_ctl_t                cur_ctl_next;
  logic [ADDR_W-1:0]      cur_addr;
  logic [ADDR_W-1:0]      cur_addr_next;
  logic                   out_valid_next;
  logic                   result_kind_next;
  logic [COUNT_OUT_W-1:0] count_value_next;
  logic [STATUS_W-1:0]    status_next;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [COUNT_WIDTH-1:0] ram_rdata;

  logic [COUNT_WIDTH-1:0]             data_eff;
  logic [COUNT_WIDTH-1:0]             data_incr;
  logic [COUNT_WIDTH+COUNT_OUT_W-1:0] data_ext;
  logic                               sat;
  logic                               ovf_now;
  logic                               out_free;
  logic                               cur_done;
  logic                               head_mem;

  kmhc_ram #(
    .WIDTH  (COUNT_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_addr),
    .rdata (ram_rdata)
  );

  assign data_eff  = fwd_hit ? fwd_data : ram_rdata;
  assign sat       = (data_eff == '1);
  assign data_incr = sat ? data_eff : data_eff + 1'b1;
  assign data_ext  = {{COUNT_OUT_W{1'b0}}, data_eff};
  assign ovf_now   = overflow | ((cur_ctl.kind == OP_INCR) & sat);
  assign out_free  = ~out_valid | ~out_stall;
  assign cur_done  = ~((cur_ctl.kind == OP_READ) | cur_ctl.stat) | out_free;
  assign head_mem  = head_valid && ((head_ctl.kind == OP_INCR) || (head_ctl.kind == OP_READ));

  always_comb begin
    state_next       = state;
    ptr_next         = ptr;
    init_next        = init_busy;
    overflow_next    = overflow;
    fwd_hit_next     = fwd_hit;
    fwd_data_next    = fwd_data;
    cur_ctl_next     = cur_ctl;
    cur_addr_next    = cur_addr;
    out_valid_next   = out_valid & out_stall;
    result_kind_next = result_kind;
    count_value_next = count_value;
    status_next      = status;
    pop              = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = cur_addr;
    ram_wdata        = data_incr;
    ram_re           = 1'b0;
    unique case (state)
      B_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr;
        ram_wdata = '0;
        ptr_next  = ptr + 1'b1;
        if (ptr == '1) begin
          state_next = B_IDLE;
          init_next  = 1'b0;
        end
      end
      B_IDLE: begin
        if (head_valid) begin
          unique case (head_ctl.kind)
            OP_INCR, OP_READ: begin
              pop           = 1'b1;
              ram_re        = 1'b1;
              cur_ctl_next  = head_ctl;
              cur_addr_next = head_addr;
              fwd_hit_next  = 1'b0;
              state_next    = B_DATA;
            end
            OP_CLEAR: begin
              pop           = 1'b1;
              overflow_next = 1'b0;
              state_next    = B_CLEAR;
            end
            OP_STAT: begin
              if (out_free) begin
                pop              = 1'b1;
                out_valid_next   = 1'b1;
                result_kind_next = RK_STATUS;
                count_value_next = '0;
                status_next      = status_code(overflow, head_ctl.seen);
              end
            end
          endcase
        end
      end
      B_DATA: begin
        if (cur_done) begin
          if (cur_ctl.kind == OP_INCR) begin
            ram_we        = 1'b1;
            overflow_next = ovf_now;
          end
          if (cur_ctl.kind == OP_READ) begin
            out_valid_next   = 1'b1;
            result_kind_next = RK_READ;
            count_value_next = data_ext[COUNT_OUT_W-1:0];
            status_next      = ST_OK;
          end else if (cur_ctl.stat) begin
            out_valid_next   = 1'b1;
            result_kind_next = RK_STATUS;
            count_value_next = '0;
            status_next      = status_code(ovf_now, cur_ctl.seen);
          end
          fwd_hit_next = 1'b0;
          state_next   = B_IDLE;
          if (head_mem) begin
            pop           = 1'b1;
            ram_re        = 1'b1;
            cur_ctl_next  = head_ctl;
            cur_addr_next = head_addr;
            fwd_hit_next  = (cur_ctl.kind == OP_INCR) && (head_addr == cur_addr);
            fwd_data_next = data_incr;
            state_next    = B_DATA;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      ptr       <= '0;
      init_busy <= 1'b1;
      overflow  <= 1'b0;
      fwd_hit   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ptr       <= ptr_next;
      init_busy <= init_next;
      overflow  <= overflow_next;
      fwd_hit   <= fwd_hit_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    fwd_data    <= fwd_data_next;
    cur_ctl     <= cur_ctl_next;
    cur_addr    <= cur_addr_next;
    result_kind <= result_kind_next;
    count_value <= count_value_next;
    status      <= status_next;
  end

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == B_CLEAR) |-> !pop)
    else $error("queue popped during table sweep");

  a_fwd_in_data: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> (state == B_DATA))
    else $error("forwarding flag set outside data state");

  a_init_once: assert property (@(posedge clk) disable iff (rst)
    !init_busy |=> !init_busy)
    else $error("initial sweep restarted without reset");

endmodule
